// File: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/pia_pkg.sv
package pia_pkg;

    // default width of a vertex index
    localparam int INDEX_BITS_DEF = 16;

    // depth of the result queue, room for two requests' worth of primitives
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // GL primitive modes
    typedef enum logic [2:0] {
        MODE_POINTS     = 3'd0,
        MODE_LINES      = 3'd1,
        MODE_LINE_LOOP  = 3'd2,
        MODE_LINE_STRIP = 3'd3,
        MODE_TRIANGLES  = 3'd4,
        MODE_TRI_STRIP  = 3'd5,
        MODE_TRI_FAN    = 3'd6,
        MODE_QUADS      = 3'd7
    } prim_mode_t;

    // kind of an emitted primitive
    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_TRI   = 2'd2
    } prim_kind_t;

    // what the assembler emits for one vertex
    typedef struct packed {
        logic [1:0] count;
        prim_kind_t kind0;
        prim_kind_t kind1;
    } emit_t;

endpackage

// File: hw/rtl/primitive_index_assembler.sv
// primitive index assembler
// input channel: one vertex index per request with the draw's primitive mode
// and an end-of-draw mark; taken when in_valid is high and in_stall is low
// output channel: point, line or triangle index tuples; taken when out_valid
// is high and out_stall is low; last_of_run marks the final tuple of a vertex
// a taken vertex is held in the input register, assembled into the result
// queue when that register moves on, and shows on the outputs from the
// queue head
// throughput: one vertex per cycle while the queue has two free slots; a
// vertex yielding two tuples (quad completion, line loop closing) is read
// out one tuple at a time from the single-read result queue
// the input register moves on only while the four-entry queue has two free
// slots, so a stalled receiver fills the queue and then raises in_stall
// reset clears the draw state (position, strip parity, held indices) and
// empties the input register and the queue
module primitive_index_assembler #(
    parameter int INDEX_BITS = pia_pkg::INDEX_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            prim_mode,
    input  logic [INDEX_BITS-1:0] vertex_index,
    input  logic                  end_of_draw,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            prim_kind,
    output logic [INDEX_BITS-1:0] index_a,
    output logic [INDEX_BITS-1:0] index_b,
    output logic [INDEX_BITS-1:0] index_c,
    output logic                  last_of_run
);

    localparam int PTR_BITS = pia_pkg::QUEUE_PTR_BITS;
    localparam int CNT_BITS = pia_pkg::QUEUE_CNT_BITS;

    logic                  s1_valid_reg;
    pia_pkg::prim_mode_t   s1_mode_reg;
    logic [INDEX_BITS-1:0] s1_vtx_reg;
    logic                  s1_eod_reg;
    logic                  s1_adv;
    logic                  in_take;

    pia_pkg::emit_t        emit;
    logic [INDEX_BITS-1:0] r0_a, r0_b, r0_c, r1_a, r1_b, r1_c;

    pia_pkg::prim_kind_t   q_kind_reg [pia_pkg::QUEUE_DEPTH];
    logic [INDEX_BITS-1:0] q_a_reg    [pia_pkg::QUEUE_DEPTH];
    logic [INDEX_BITS-1:0] q_b_reg    [pia_pkg::QUEUE_DEPTH];
    logic [INDEX_BITS-1:0] q_c_reg    [pia_pkg::QUEUE_DEPTH];
    logic                  q_last_reg [pia_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS-1:0]   wr_ptr_1;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   push_n;
    logic                  pop;

    // handshake on the input register
    assign s1_adv   = s1_valid_reg && (count_reg <= CNT_BITS'(pia_pkg::QUEUE_DEPTH - 2));
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg <= pia_pkg::prim_mode_t'(prim_mode);
            s1_vtx_reg  <= vertex_index;
            s1_eod_reg  <= end_of_draw;
        end
    end

    pia_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_adv),
        .mode  (s1_mode_reg),
        .vtx   (s1_vtx_reg),
        .eod   (s1_eod_reg),
        .emit  (emit),
        .r0_a  (r0_a),
        .r0_b  (r0_b),
        .r0_c  (r0_c),
        .r1_a  (r1_a),
        .r1_b  (r1_b),
        .r1_c  (r1_c)
    );

    // result queue pointers and fill
    assign pop         = out_valid && !out_stall;
    assign push_n      = s1_adv ? CNT_BITS'(emit.count) : '0;
    assign wr_ptr_1    = wr_ptr_reg + PTR_BITS'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
    assign count_next  = count_reg + push_n - CNT_BITS'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (s1_adv && emit.count != 2'd0)
        begin
            q_kind_reg[wr_ptr_reg] <= emit.kind0;
            q_a_reg[wr_ptr_reg]    <= r0_a;
            q_b_reg[wr_ptr_reg]    <= r0_b;
            q_c_reg[wr_ptr_reg]    <= r0_c;
            q_last_reg[wr_ptr_reg] <= (emit.count == 2'd1);
        end
        if (s1_adv && emit.count == 2'd2)
        begin
            q_kind_reg[wr_ptr_1] <= emit.kind1;
            q_a_reg[wr_ptr_1]    <= r1_a;
            q_b_reg[wr_ptr_1]    <= r1_b;
            q_c_reg[wr_ptr_1]    <= r1_c;
            q_last_reg[wr_ptr_1] <= 1'b1;
        end
    end

    // head of the queue drives the output
    assign out_valid   = (count_reg != '0);
    assign prim_kind   = q_kind_reg[rd_ptr_reg];
    assign index_a     = q_a_reg[rd_ptr_reg];
    assign index_b     = q_b_reg[rd_ptr_reg];
    assign index_c     = q_c_reg[rd_ptr_reg];
    assign last_of_run = q_last_reg[rd_ptr_reg];

endmodule

// File: hw/rtl/pia_core.sv
module pia_core #(
    parameter int INDEX_BITS = pia_pkg::INDEX_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  pia_pkg::prim_mode_t    mode,
    input  logic [INDEX_BITS-1:0]  vtx,
    input  logic                   eod,
    output pia_pkg::emit_t         emit,
    output logic [INDEX_BITS-1:0]  r0_a,
    output logic [INDEX_BITS-1:0]  r0_b,
    output logic [INDEX_BITS-1:0]  r0_c,
    output logic [INDEX_BITS-1:0]  r1_a,
    output logic [INDEX_BITS-1:0]  r1_b,
    output logic [INDEX_BITS-1:0]  r1_c
);

    logic [1:0]            position_reg, position_next;
    logic                  parity_reg, parity_next;
    logic [INDEX_BITS-1:0] anchor_reg, anchor_next;
    logic [INDEX_BITS-1:0] older_reg, older_next;
    logic [INDEX_BITS-1:0] newer_reg, newer_next;

    // assemble primitives from held vertices and the incoming one
    always_comb
    begin
        position_next = position_reg;
        parity_next   = parity_reg;
        anchor_next   = anchor_reg;
        older_next    = older_reg;
        newer_next    = newer_reg;
        emit.count    = 2'd0;
        emit.kind0    = pia_pkg::KIND_POINT;
        emit.kind1    = pia_pkg::KIND_POINT;
        r0_a = '0;
        r0_b = '0;
        r0_c = '0;
        r1_a = '0;
        r1_b = '0;
        r1_c = '0;

        case (mode)
            pia_pkg::MODE_POINTS:
            begin
                emit.count    = 2'd1;
                emit.kind0    = pia_pkg::KIND_POINT;
                r0_a          = vtx;
                position_next = 2'd0;
            end
            pia_pkg::MODE_LINES:
            begin
                if (position_reg == 2'd0)
                begin
                    newer_next    = vtx;
                    position_next = 2'd1;
                end
                else
                begin
                    emit.count    = 2'd1;
                    emit.kind0    = pia_pkg::KIND_LINE;
                    r0_a          = newer_reg;
                    r0_b          = vtx;
                    position_next = 2'd0;
                end
            end
            pia_pkg::MODE_LINE_LOOP:
            begin
                if (position_reg == 2'd0)
                begin
                    anchor_next = vtx;
                end
                else
                begin
                    emit.count = 2'd1;
                    emit.kind0 = pia_pkg::KIND_LINE;
                    r0_a       = newer_reg;
                    r0_b       = vtx;
                end
                // closing line follows the chaining line
                if (eod && position_reg >= 2'd2)
                begin
                    emit.count = 2'd2;
                    emit.kind1 = pia_pkg::KIND_LINE;
                    r1_a       = vtx;
                    r1_b       = anchor_reg;
                end
                newer_next    = vtx;
                position_next = (position_reg == 2'd3) ? 2'd3 : position_reg + 2'd1;
            end
            pia_pkg::MODE_LINE_STRIP:
            begin
                if (position_reg != 2'd0)
                begin
                    emit.count = 2'd1;
                    emit.kind0 = pia_pkg::KIND_LINE;
                    r0_a       = newer_reg;
                    r0_b       = vtx;
                end
                newer_next    = vtx;
                position_next = 2'd1;
            end
            pia_pkg::MODE_TRIANGLES:
            begin
                if (position_reg == 2'd0)
                begin
                    older_next    = vtx;
                    position_next = 2'd1;
                end
                else if (position_reg == 2'd1)
                begin
                    newer_next    = vtx;
                    position_next = 2'd2;
                end
                else
                begin
                    emit.count    = 2'd1;
                    emit.kind0    = pia_pkg::KIND_TRI;
                    r0_a          = older_reg;
                    r0_b          = newer_reg;
                    r0_c          = vtx;
                    position_next = 2'd0;
                end
            end
            pia_pkg::MODE_TRI_STRIP:
            begin
                if (position_reg >= 2'd2)
                begin
                    emit.count = 2'd1;
                    emit.kind0 = pia_pkg::KIND_TRI;
                    // odd triangles swap the first two corners
                    r0_a       = parity_reg ? newer_reg : older_reg;
                    r0_b       = parity_reg ? older_reg : newer_reg;
                    r0_c       = vtx;
                    parity_next = ~parity_reg;
                end
                older_next    = newer_reg;
                newer_next    = vtx;
                position_next = (position_reg >= 2'd2) ? 2'd2 : position_reg + 2'd1;
            end
            pia_pkg::MODE_TRI_FAN:
            begin
                if (position_reg == 2'd0)
                begin
                    anchor_next = vtx;
                end
                else if (position_reg >= 2'd2)
                begin
                    emit.count = 2'd1;
                    emit.kind0 = pia_pkg::KIND_TRI;
                    r0_a       = anchor_reg;
                    r0_b       = newer_reg;
                    r0_c       = vtx;
                end
                newer_next    = vtx;
                position_next = (position_reg >= 2'd2) ? 2'd2 : position_reg + 2'd1;
            end
            pia_pkg::MODE_QUADS:
            begin
                if (position_reg == 2'd0)
                begin
                    anchor_next   = vtx;
                    position_next = 2'd1;
                end
                else if (position_reg == 2'd1)
                begin
                    older_next    = vtx;
                    position_next = 2'd2;
                end
                else if (position_reg == 2'd2)
                begin
                    newer_next    = vtx;
                    position_next = 2'd3;
                end
                else
                begin
                    // split the quad into two triangles
                    emit.count    = 2'd2;
                    emit.kind0    = pia_pkg::KIND_TRI;
                    emit.kind1    = pia_pkg::KIND_TRI;
                    r0_a          = anchor_reg;
                    r0_b          = older_reg;
                    r0_c          = newer_reg;
                    r1_a          = anchor_reg;
                    r1_b          = newer_reg;
                    r1_c          = vtx;
                    position_next = 2'd0;
                end
            end
            default:
            begin
                position_next = 2'd0;
            end
        endcase

        // end of draw drops any partial group
        if (eod)
        begin
            position_next = 2'd0;
            parity_next   = 1'b0;
        end
    end

    // held draw state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= 2'd0;
            parity_reg   <= 1'b0;
            anchor_reg   <= '0;
            older_reg    <= '0;
            newer_reg    <= '0;
        end
        else if (step)
        begin
            position_reg <= position_next;
            parity_reg   <= parity_next;
            anchor_reg   <= anchor_next;
            older_reg    <= older_next;
            newer_reg    <= newer_next;
        end
    end

endmodule

// File: hw/rtl/pia_checker.sv
`include "assert_macros.svh"

module pia_checker #(
    parameter int INDEX_BITS = pia_pkg::INDEX_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic [2:0]            prim_mode,
    input logic [INDEX_BITS-1:0] vertex_index,
    input logic                  end_of_draw,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [1:0]            prim_kind,
    input logic [INDEX_BITS-1:0] index_a,
    input logic [INDEX_BITS-1:0] index_b,
    input logic [INDEX_BITS-1:0] index_c,
    input logic                  last_of_run
);

    // a stalled request holds
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
        in_valid && $stable(prim_mode) && $stable(vertex_index) && $stable(end_of_draw))

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(prim_kind) && $stable(index_a) && $stable(last_of_run))

    // the second tuple of a vertex is already queued behind the first
    `ASSERT_NEXT(a_run_follows, clk, rst_n, out_valid && !out_stall && !last_of_run, out_valid)

    // points carry no second or third corner
    `ASSERT_SAME(a_point_zero, clk, rst_n, out_valid && prim_kind == pia_pkg::KIND_POINT,
        index_b == '0 && index_c == '0)

    // only known kinds, and lines carry no third corner
    `ASSERT_SAME(a_kind_known, clk, rst_n, out_valid,
        prim_kind == pia_pkg::KIND_TRI ||
        (prim_kind == pia_pkg::KIND_LINE && index_c == '0) ||
        prim_kind == pia_pkg::KIND_POINT)

endmodule

bind primitive_index_assembler pia_checker #(.INDEX_BITS(INDEX_BITS)) u_pia_checker (.*);

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pia_pkg::*;

    localparam int IW = 16;
    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1900;
    localparam int PRESSURE_AT = 700;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 40;
    localparam int DIRECTED_ROWS = 30;

    // one assembled primitive as seen on the output channel
    typedef struct packed {
        prim_kind_t    kind;
        logic [IW-1:0] a;
        logic [IW-1:0] b;
        logic [IW-1:0] c;
        logic          last;
    } prim_t;

    // one vertex request, with a typed-in single result where it is obvious
    typedef struct packed {
        prim_mode_t    mode;
        logic [IW-1:0] idx;
        logic          eod;
        logic          typed;
        prim_kind_t    kind;
        logic [IW-1:0] a;
        logic [IW-1:0] b;
        logic [IW-1:0] c;
    } vertex_row_t;

    // directed vertices: extremes, every mode, loop closing, strip swap,
    // dropped trailing group and a mode change within a draw
    localparam vertex_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_POINTS,     16'h0000, 1'b0, 1'b1, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_POINTS,     16'hFFFF, 1'b1, 1'b1, KIND_POINT, 16'hFFFF, 16'h0000, 16'h0000},
        '{MODE_LINES,      16'hFFFF, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_LINES,      16'h0000, 1'b1, 1'b1, KIND_LINE,  16'hFFFF, 16'h0000, 16'h0000},
        '{MODE_LINE_LOOP,  16'h0001, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_LINE_LOOP,  16'h0002, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_LINE_LOOP,  16'h0003, 1'b1, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_LINE_LOOP,  16'h0009, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_LINE_LOOP,  16'h000A, 1'b1, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_LINE_STRIP, 16'h0005, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_LINE_STRIP, 16'h0006, 1'b1, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRIANGLES,  16'h0001, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRIANGLES,  16'h0002, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRIANGLES,  16'h0003, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRIANGLES,  16'h0004, 1'b1, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRI_STRIP,  16'h0010, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRI_STRIP,  16'h0011, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRI_STRIP,  16'h0012, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRI_STRIP,  16'h0013, 1'b1, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRI_FAN,    16'h0020, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRI_FAN,    16'h0021, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRI_FAN,    16'h0022, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRI_FAN,    16'h0023, 1'b1, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_QUADS,      16'h0030, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_QUADS,      16'h0031, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_QUADS,      16'h0032, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_QUADS,      16'h0033, 1'b1, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_QUADS,      16'h0040, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_QUADS,      16'h0041, 1'b0, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000},
        '{MODE_TRI_FAN,    16'h0042, 1'b1, 1'b0, KIND_POINT, 16'h0000, 16'h0000, 16'h0000}
    };

    logic          clk = 1'b0;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [2:0]    prim_mode;
    logic [IW-1:0] vertex_index;
    logic          end_of_draw;
    logic          out_valid;
    logic          out_stall;
    logic [1:0]    prim_kind;
    logic [IW-1:0] index_a;
    logic [IW-1:0] index_b;
    logic [IW-1:0] index_c;
    logic          last_of_run;

    // assembler state kept by the predictor
    logic [1:0]    asm_position;
    logic          asm_parity;
    logic [IW-1:0] asm_anchor;
    logic [IW-1:0] asm_older;
    logic [IW-1:0] asm_newer;

    prim_t expected_prims[$];
    int    mismatches = 0;
    int    vertices_sent = 0;
    bit    hold_off_request = 1'b0;

    primitive_index_assembler #(
        .INDEX_BITS(IW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .prim_mode(prim_mode),
        .vertex_index(vertex_index),
        .end_of_draw(end_of_draw),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .prim_kind(prim_kind),
        .index_a(index_a),
        .index_b(index_b),
        .index_c(index_c),
        .last_of_run(last_of_run)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic prim_t make_prim(input prim_kind_t kind, input logic [IW-1:0] a,
                                        input logic [IW-1:0] b, input logic [IW-1:0] c);
        prim_t p;
        p.kind = kind;
        p.a = a;
        p.b = b;
        p.c = c;
        p.last = 1'b0;
        return p;
    endfunction

    // assemble one vertex into zero, one or two primitives and move the draw state on
    function automatic int assemble_vertex(input prim_mode_t mode, input logic [IW-1:0] v,
                                           input logic eod, output prim_t r0, output prim_t r1);
        prim_t      r[2];
        int         n;
        logic [1:0] p;
        n = 0;
        p = asm_position;
        r[0] = '0;
        r[1] = '0;
        case (mode)
            MODE_POINTS:
            begin
                r[n] = make_prim(KIND_POINT, v, '0, '0);
                n++;
                asm_position = 2'd0;
            end
            MODE_LINES:
            begin
                if (p == 2'd0)
                begin
                    asm_newer = v;
                    asm_position = 2'd1;
                end
                else
                begin
                    r[n] = make_prim(KIND_LINE, asm_newer, v, '0);
                    n++;
                    asm_position = 2'd0;
                end
            end
            MODE_LINE_LOOP:
            begin
                if (p == 2'd0)
                    asm_anchor = v;
                else
                begin
                    r[n] = make_prim(KIND_LINE, asm_newer, v, '0);
                    n++;
                end
                // closing line once three or more vertices arrived
                if (eod && p >= 2'd2)
                begin
                    r[n] = make_prim(KIND_LINE, v, asm_anchor, '0);
                    n++;
                end
                asm_newer = v;
                asm_position = (p < 2'd3) ? p + 2'd1 : 2'd3;
            end
            MODE_LINE_STRIP:
            begin
                if (p != 2'd0)
                begin
                    r[n] = make_prim(KIND_LINE, asm_newer, v, '0);
                    n++;
                end
                asm_newer = v;
                asm_position = 2'd1;
            end
            MODE_TRIANGLES:
            begin
                if (p == 2'd0)
                begin
                    asm_older = v;
                    asm_position = 2'd1;
                end
                else if (p == 2'd1)
                begin
                    asm_newer = v;
                    asm_position = 2'd2;
                end
                else
                begin
                    r[n] = make_prim(KIND_TRI, asm_older, asm_newer, v);
                    n++;
                    asm_position = 2'd0;
                end
            end
            MODE_TRI_STRIP:
            begin
                // odd triangles swap their first two indices
                if (p >= 2'd2)
                begin
                    if (asm_parity)
                        r[n] = make_prim(KIND_TRI, asm_newer, asm_older, v);
                    else
                        r[n] = make_prim(KIND_TRI, asm_older, asm_newer, v);
                    n++;
                    asm_parity = ~asm_parity;
                end
                asm_older = asm_newer;
                asm_newer = v;
                asm_position = (p < 2'd2) ? p + 2'd1 : 2'd2;
            end
            MODE_TRI_FAN:
            begin
                if (p == 2'd0)
                    asm_anchor = v;
                else if (p >= 2'd2)
                begin
                    r[n] = make_prim(KIND_TRI, asm_anchor, asm_newer, v);
                    n++;
                end
                asm_newer = v;
                asm_position = (p < 2'd2) ? p + 2'd1 : 2'd2;
            end
            default:
            begin
                // quads: hold three vertices, split on the fourth
                if (p == 2'd0)
                begin
                    asm_anchor = v;
                    asm_position = 2'd1;
                end
                else if (p == 2'd1)
                begin
                    asm_older = v;
                    asm_position = 2'd2;
                end
                else if (p == 2'd2)
                begin
                    asm_newer = v;
                    asm_position = 2'd3;
                end
                else
                begin
                    r[0] = make_prim(KIND_TRI, asm_anchor, asm_older, asm_newer);
                    r[1] = make_prim(KIND_TRI, asm_anchor, asm_newer, v);
                    n = 2;
                    asm_position = 2'd0;
                end
            end
        endcase
        // end of draw drops any partial group
        if (eod)
        begin
            asm_position = 2'd0;
            asm_parity = 1'b0;
        end
        if (n > 0)
            r[n-1].last = 1'b1;
        r0 = r[0];
        r1 = r[1];
        return n;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [IW-1:0] got,
                               input logic [IW-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // vertex index: extremes, runs from a base, or anything
    function automatic logic [IW-1:0] pick_index(input logic [IW-1:0] base, input int k);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3, 4: return base + IW'(k);
            default: return IW'($urandom);
        endcase
    endfunction

    // offer one vertex request after a random gap, then record what it should yield
    task automatic offer_vertex(input vertex_row_t row, input bit calm);
        prim_t r0;
        prim_t r1;
        prim_t typed_prim;
        int    n;
        int    gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        prim_mode <= row.mode;
        vertex_index <= row.idx;
        end_of_draw <= row.eod;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = assemble_vertex(row.mode, row.idx, row.eod, r0, r1);
        if (row.typed)
        begin
            typed_prim = make_prim(row.kind, row.a, row.b, row.c);
            typed_prim.last = 1'b1;
            expected_prims.push_back(typed_prim);
        end
        else
        begin
            if (n > 0)
                expected_prims.push_back(r0);
            if (n > 1)
                expected_prims.push_back(r1);
        end
        vertices_sent++;
        @(negedge clk);
    endtask

    // output check against the oldest expected primitive
    always @(posedge clk)
    begin
        prim_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_prims.size() == 0)
                report_mismatch("primitive arrived with nothing expected");
            else
            begin
                want = expected_prims.pop_front();
                check_field("prim_kind", IW'(prim_kind), IW'(want.kind));
                check_field("index_a", index_a, want.a);
                check_field("index_b", index_b, want.b);
                check_field("index_c", index_c, want.c);
                check_field("last_of_run", IW'(last_of_run), IW'(want.last));
            end
        end
    end

    // receiver: random stall per primitive, calm stretches, one long hold-off
    initial
    begin
        int stall_for;
        int taken;
        bit calm;
        taken = 0;
        calm = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                stall_for = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            else
                stall_for = calm ? 0 : $urandom_range(0, 3);
            if (stall_for > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_for) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            taken++;
            if (taken % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            @(negedge clk);
        end
    end

    // run limit
    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // reset, directed table, then random draws
    initial
    begin
        int          k;
        int          len;
        prim_mode_t  mode;
        logic [IW-1:0] base;
        bit          calm;
        vertex_row_t row;
        rst_n = 1'b0;
        in_valid = 1'b0;
        prim_mode = MODE_POINTS;
        vertex_index = '0;
        end_of_draw = 1'b0;
        asm_position = 2'd0;
        asm_parity = 1'b0;
        asm_anchor = '0;
        asm_older = '0;
        asm_newer = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (k = 0; k < DIRECTED_ROWS; k++)
            offer_vertex(DIRECTED[k], 1'b0);

        // well-formed draws with random content, some mode changes and early ends
        while (vertices_sent < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            mode = prim_mode_t'($urandom_range(0, 7));
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            base = IW'($urandom);
            calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < len; k++)
            begin
                row = '0;
                row.mode = ($urandom_range(0, 19) == 0) ? prim_mode_t'($urandom_range(0, 7))
                                                         : mode;
                row.idx = pick_index(base, k);
                row.eod = (k == len - 1) || ($urandom_range(0, 39) == 0);
                if (vertices_sent == PRESSURE_AT)
                    hold_off_request = 1'b1;
                offer_vertex(row, calm);
            end
        end
        in_valid <= 1'b0;

        // drain
        while (expected_prims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pia_pkg.sv
hw/rtl/pia_core.sv
hw/rtl/primitive_index_assembler.sv
hw/rtl/pia_checker.sv
tb/tb.sv
